// ===== rtl/lcdt_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdt_pkg
// Shared constants and controller/datapath interface types for the LFSR
// counter decode table.
// ----------------------------------------------------------------------------
package lcdt_pkg;

    localparam int DEF_STATE_BITS   = 15;
    localparam int DEF_FEEDBACK_TAP = 13;

    localparam int RAW_W     = 15;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_STATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_INV   = 8'd1;

    localparam logic FUNC_BUILD  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic build_start;
        logic fill_en;
        logic walk_en;
        logic look_en;
        logic load_look;
        logic load_build;
    } lcdt_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic walk_last;
    } lcdt_status_t;

endpackage

// ===== rtl/lcdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcdt_ctrl
// Controller: build sequencing, lookup pending flag and result handshake.
// ----------------------------------------------------------------------------
module lcdt_ctrl
    import lcdt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_func,
    output logic         m_valid,
    input  logic         m_ready,
    output lcdt_cmd_t    cmd,
    input  lcdt_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !(pend_reg && !out_free);
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.look_en     = accept && (s_func == FUNC_LOOKUP);
        cmd.load_look   = pend_reg && out_free;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_func == FUNC_BUILD)) begin
                    cmd.build_start = 1'b1;
                    state_next      = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_en = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.walk_en = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!pend_reg && out_free) begin
                    cmd.load_build = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        pend_next = pend_reg;
        if (cmd.look_en) begin
            pend_next = 1'b1;
        end else if (cmd.load_look) begin
            pend_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (cmd.load_look || cmd.load_build) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/lcdt_datapath.sv =====
// ----------------------------------------------------------------------------
// lcdt_datapath
// Datapath: configuration registers, LFSR walker, decode table memory and
// result register.
// ----------------------------------------------------------------------------
module lcdt_datapath
    import lcdt_pkg::*;
#(
    parameter int STATE_BITS   = DEF_STATE_BITS,
    parameter int FEEDBACK_TAP = DEF_FEEDBACK_TAP
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [RAW_W-1:0]     raw_value,
    input  lcdt_cmd_t            cmd,
    output lcdt_status_t         status,
    output logic [COUNT_W-1:0]   count_value
);

    localparam int W = STATE_BITS;
    localparam logic [W-1:0] SMASK    = {W{1'b1}};
    localparam logic [W-1:0] WALK_END = SMASK - 1'b1;
    localparam logic [W:0]   NSTATES  = {1'b1, {W{1'b0}}};

    logic [W-1:0] mem [0:(1<<W)-1];

    logic [CFG_W-1:0]   zsv_reg;
    logic               inv_reg;
    logic [W-1:0]       lfsr_reg, lfsr_next;
    logic [W-1:0]       step_reg, step_next;
    logic [W-1:0]       sweep_reg, sweep_next;
    logic [W-1:0]       rdata_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [W-1:0]         lfsr_adv;
    logic [W-1:0]         step_adv;
    logic [W-1:0]         fill_val;
    logic [W-1:0]         look_addr;
    logic [W-1:0]         wr_addr;
    logic [W-1:0]         wr_data;
    logic [W+CFG_W-1:0]   zsv_ext;
    logic [W+RAW_W-1:0]   raw_ext;
    logic [W+COUNT_W-1:0] rdata_ext;
    logic [W+COUNT_W:0]   nst_ext;

    assign zsv_ext   = {{W{1'b0}}, zsv_reg};
    assign fill_val  = zsv_ext[W-1:0];
    assign raw_ext   = {{W{1'b0}}, raw_value};
    assign look_addr = raw_ext[W-1:0];
    assign rdata_ext = {{COUNT_W{1'b0}}, rdata_reg};
    assign nst_ext   = {{COUNT_W{1'b0}}, NSTATES};

    assign lfsr_adv = {lfsr_reg[W-2:0], lfsr_reg[W-1] ^ lfsr_reg[FEEDBACK_TAP]};
    assign step_adv = (step_reg == WALK_END) ? '0 : step_reg + 1'b1;

    assign status.fill_last = (sweep_reg == SMASK);
    assign status.walk_last = (sweep_reg == WALK_END);

    assign wr_addr = cmd.walk_en ? (lfsr_adv ^ {W{inv_reg}}) : sweep_reg;
    assign wr_data = cmd.walk_en ? step_adv : fill_val;

    always_comb begin
        lfsr_next  = lfsr_reg;
        step_next  = step_reg;
        sweep_next = sweep_reg;
        if (cmd.build_start) begin
            lfsr_next  = SMASK;
            step_next  = '0;
            sweep_next = '0;
        end else if (cmd.fill_en) begin
            sweep_next = status.fill_last ? '0 : sweep_reg + 1'b1;
        end else if (cmd.walk_en) begin
            lfsr_next  = lfsr_adv;
            step_next  = step_adv;
            sweep_next = sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zsv_reg   <= '0;
            inv_reg   <= 1'b0;
            lfsr_reg  <= SMASK;
            step_reg  <= '0;
            sweep_reg <= '0;
        end else begin
            if (cfg_we && (cfg_index == CFG_ZERO_STATE)) begin
                zsv_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_DATA_INV)) begin
                inv_reg <= cfg_data[0];
            end
            lfsr_reg  <= lfsr_next;
            step_reg  <= step_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill_en || cmd.walk_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.look_en) begin
            rdata_reg <= mem[look_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_look) begin
            count_reg <= rdata_ext[COUNT_W-1:0];
        end else if (cmd.load_build) begin
            count_reg <= nst_ext[COUNT_W-1:0];
        end
    end

    assign count_value = count_reg;

endmodule

// ===== rtl/lfsr_count_decode_table.sv =====
// lookup: one accepted per cycle unless the result stalls; the table read is registered,
//   then the result register loads once the output is free
// build: fills every table entry, then walks the LFSR sequence through the single table
//   write port, returns the entry count once the output is free; no item is taken meanwhile
// reset clears control state and config registers; the table is undefined until a build
// ----------------------------------------------------------------------------
// lfsr_count_decode_table
// Top level: decodes raw LFSR pixel counter bits into a binary count through a
// table built by walking the LFSR sequence.
// ----------------------------------------------------------------------------
module lfsr_count_decode_table
    import lcdt_pkg::*;
#(
    parameter int STATE_BITS   = DEF_STATE_BITS,
    parameter int FEEDBACK_TAP = DEF_FEEDBACK_TAP
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  logic [RAW_W-1:0]     s_raw_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COUNT_W-1:0]   m_count_value,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    lcdt_cmd_t    cmd;
    lcdt_status_t status;

    assign cfg_ready = 1'b1;

    lcdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    lcdt_datapath #(
        .STATE_BITS   (STATE_BITS),
        .FEEDBACK_TAP (FEEDBACK_TAP)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .raw_value   (s_raw_value),
        .cmd         (cmd),
        .status      (status),
        .count_value (m_count_value)
    );

endmodule

// ===== rtl/lcdt_checker.sv =====
// ----------------------------------------------------------------------------
// lcdt_checker
// Port-level checks for the LFSR counter decode table, bound to the top level.
// ----------------------------------------------------------------------------
module lcdt_checker
    import lcdt_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_func,
    input logic               m_valid,
    input logic               m_ready,
    input logic [COUNT_W-1:0] m_count_value
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count_value))
        else $error("result dropped or changed while stalled");

    // a build blocks further items right away
    a_build_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == FUNC_BUILD) |=> !s_ready)
        else $error("item taken during build");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // no result straight out of reset: m_valid rises only with reset already released
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(aresetn))
        else $error("result raised out of reset");

endmodule

bind lfsr_count_decode_table lcdt_checker u_lcdt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_func        (s_func),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_count_value (m_count_value)
);

// ===== verif/tb_lfsr_count_decode_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lfsr_count_decode_table
// Self-checking bench for the LFSR counter decode table. Builds the table
// under several register settings, then decodes directed and random raw
// values. Lookup results are compared with an in-bench copy of the table,
// build results with the entry count. Random idle and stall bursts, a long
// output hold-off and a final back-to-back stretch exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_lfsr_count_decode_table;
    import lcdt_pkg::*;

    localparam int NBITS        = DEF_STATE_BITS;
    localparam int TAP          = DEF_FEEDBACK_TAP;
    localparam int NENTRIES     = 1 << NBITS;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam int REPORT_MAX   = 10;
    localparam logic [COUNT_W-1:0] BUILD_COUNT = COUNT_W'(NENTRIES);

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_func;
    logic [RAW_W-1:0]     s_raw_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [COUNT_W-1:0]   m_count_value;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // in-bench copy of the table and its registers
    logic [NBITS-1:0]   decode_copy [NENTRIES];
    logic [CFG_W-1:0]   zero_fill_reg;
    logic               invert_reg;
    logic [COUNT_W-1:0] pending_counts [$];

    bit          idle_enable = 1'b1;
    logic        sink_blocked = 1'b0;
    int          sink_gap = 0;
    int          error_count = 0;
    int          results_checked = 0;
    int          builds_sent = 0;
    int          lookups_sent = 0;
    int          settings_written = 0;
    int unsigned cycle_count = 0;

    lfsr_count_decode_table DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_raw_value   (s_raw_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_count_value (m_count_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [NBITS-1:0] lfsr_advance(input logic [NBITS-1:0] s);
        return {s[NBITS-2:0], s[NBITS-1] ^ s[TAP]};
    endfunction

    function automatic void build_decode_copy();
        int               i;
        logic [NBITS-1:0] walk_state;
        logic [NBITS-1:0] walk_count;
        logic [NBITS-1:0] addr;
        for (i = 0; i < NENTRIES; i++) begin
            decode_copy[i] = zero_fill_reg[NBITS-1:0];
        end
        walk_state = '1;
        walk_count = '0;
        for (i = 0; i < NENTRIES - 1; i++) begin
            walk_state = lfsr_advance(walk_state);
            walk_count = (walk_count == NBITS'(NENTRIES - 2)) ? '0 : walk_count + 1'b1;
            addr = invert_reg ? ~walk_state : walk_state;
            decode_copy[addr] = walk_count;
        end
    endfunction

    function automatic logic [COUNT_W-1:0] predict_count(input logic func,
                                                         input logic [RAW_W-1:0] raw);
        if (func == FUNC_BUILD) begin
            build_decode_copy();
            return BUILD_COUNT;
        end
        return COUNT_W'(decode_copy[raw[NBITS-1:0]]);
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return RAW_W'(1) << $urandom_range(0, RAW_W - 1);
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic void log_error(input string what);
        if (error_count < REPORT_MAX) begin
            $display("[%0t] %s", $time, what);
        end
        error_count++;
    endfunction

    task automatic offer_item(input logic func, input logic [RAW_W-1:0] raw);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_raw_value <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_counts.push_back(predict_count(func, raw));
        if (func == FUNC_BUILD) begin
            builds_sent++;
        end else begin
            lookups_sent++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_ZERO_STATE) begin
            zero_fill_reg = value;
        end else if (idx == CFG_DATA_INV) begin
            invert_reg = value[0];
        end
    endtask

    task automatic configure(input logic [CFG_W-1:0] zero_val, input logic [CFG_W-1:0] inv_val);
        write_register(CFG_ZERO_STATE, zero_val);
        write_register(CFG_DATA_INV, inv_val);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    task automatic test_reset_table();
        offer_item(FUNC_BUILD, '1);
        offer_item(FUNC_LOOKUP, 15'h0000);
        offer_item(FUNC_LOOKUP, 15'h7FFF);
        offer_item(FUNC_LOOKUP, 15'h0001);
        offer_item(FUNC_LOOKUP, 15'h4000);
        offer_item(FUNC_LOOKUP, 15'h5555);
        offer_item(FUNC_LOOKUP, 15'h2AAA);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        configure(15'h7FFF, 15'h0001);
        offer_item(FUNC_BUILD, 15'h5555);
        offer_item(FUNC_LOOKUP, 15'h0000);
        offer_item(FUNC_LOOKUP, 15'h7FFF);
        offer_item(FUNC_LOOKUP, 15'h0001);
        offer_item(FUNC_LOOKUP, 15'h7FFE);
        wait_drained();
    endtask

    task automatic test_ignored_writes();
        // out-of-range indexes must leave both registers alone
        write_register(8'd2, 15'h1234);
        write_register(8'h80, 15'h0000);
        write_register(8'hFF, 15'h0AAA);
        cfg_valid <= 1'b0;
        // two builds in a row, each one runs in full
        offer_item(FUNC_BUILD, 15'h0000);
        offer_item(FUNC_BUILD, 15'h2AAA);
        offer_item(FUNC_LOOKUP, 15'h0000);
        offer_item(FUNC_LOOKUP, 15'h7FFF);
        offer_item(FUNC_LOOKUP, 15'h1234);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        int n;
        idle_enable = 1'b0;
        fork
            begin
                sink_blocked <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_blocked <= 1'b0;
            end
        join_none
        for (n = 0; n < 40; n++) begin
            offer_item(FUNC_LOOKUP, pick_raw());
        end
        wait_drained();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_phases();
        int phase;
        int n;
        for (phase = 0; phase < 3; phase++) begin
            configure(CFG_W'($urandom_range(0, 32767)), CFG_W'($urandom_range(0, 32767)));
            offer_item(FUNC_BUILD, pick_raw());
            for (n = 0; n < 220; n++) begin
                offer_item(FUNC_LOOKUP, pick_raw());
            end
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        int n;
        idle_enable = 1'b0;
        for (n = 0; n < 150; n++) begin
            offer_item(FUNC_LOOKUP, pick_raw());
        end
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_blocked) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            m_ready  <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            m_ready  <= 1'b0;
            sink_gap <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        logic [COUNT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                log_error($sformatf("unexpected result count_value=%0d", m_count_value));
            end else begin
                want = pending_counts.pop_front();
                results_checked++;
                if (m_count_value !== want) begin
                    log_error($sformatf("count_value mismatch: expected %0d, got %0d",
                                        want, m_count_value));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    initial begin : run_tests
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_func      <= FUNC_LOOKUP;
        s_raw_value <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_ZERO_STATE;
        cfg_data    <= '0;
        zero_fill_reg = '0;
        invert_reg    = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_table();
        test_register_extremes();
        test_ignored_writes();
        test_output_backpressure();
        test_random_phases();
        test_back_to_back();

        repeat (SETTLE) @(posedge aclk);
        if (pending_counts.size() != 0) begin
            log_error($sformatf("%0d results never arrived", pending_counts.size()));
        end
        $display("covered %0d table builds and %0d lookups over %0d register settings",
                 builds_sent, lookups_sent, settings_written + 1);
        $display("%0d results compared, %0d errors, %0d cycles",
                 results_checked, error_count, cycle_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
